### src/raster_word_pattern_counter_defines.svh
// Assertion macros shared by the checker file
`ifndef RASTER_WORD_PATTERN_COUNTER_DEFINES_SVH
`define RASTER_WORD_PATTERN_COUNTER_DEFINES_SVH

// same-cycle implication
`define RWPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rwpc_pkg.sv
package rwpc_pkg;

  localparam int MaxWidth = 256;
  localparam int MaxLen   = 4;

  localparam int ColW  = $clog2(MaxWidth + 1);
  localparam int AddrW = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxLen);
  localparam int LenW  = $clog2(MaxLen + 1);
  localparam int HitW  = 3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgPatternChars  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternLength = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCrossMode     = 2'd2;

  localparam logic [31:0] PatternCharsRst  = 32'h5341_4D58;
  localparam logic [2:0]  PatternLengthRst = 3'd4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       row_end;
    logic       frame_end;
  } rwpc_in_t;

  typedef struct packed {
    logic [31:0] match_total;
    logic        width_overflow;
  } rwpc_out_t;

endpackage

### src/raster_word_pattern_counter.sv
// A frame_end transfer yields its result through the stage 1 registers and the result register.
// Throughput: one character per cycle unless the pipe stalls; the line store is one read
// and one write port, with a single-entry forward covering back-to-back same-column accesses.
// The output register lets the next character enter while a result waits.
// Reset (rst_ni low, async): registers return to "XMAS", length 4, line mode; window,
// counters, total and overflow clear. The line store is not cleared.
module raster_word_pattern_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rwpc_pkg::rwpc_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rwpc_pkg::rwpc_out_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [rwpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rwpc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rwpc_pkg::*;

  typedef logic [MaxLen-1:0][MaxLen-1:0][7:0] win_t;
  typedef logic [MaxLen-1:0][7:0]             seq_t;
  typedef logic [MaxLen-2:0][7:0]             line_word_t;

  // config
  logic [31:0] pattern_chars_q;
  logic [2:0]  pattern_len_q;
  logic        cross_q;

  // stage 0
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] rows_q, rows_d;
  logic            in_width0;
  logic            stall;
  logic            advance;
  logic            in_fire;

  // line store
  line_word_t line_mem [MaxWidth];
  line_word_t rd_q;
  line_word_t fwd_data_q;
  logic       fwd_q;
  logic       wr_en;
  line_word_t wr_data;
  line_word_t line_rd;

  // stage 1
  logic            s1_valid_q;
  logic [7:0]      s1_ch_q;
  logic            s1_fe_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_rows_q;
  logic            s1_in_width_q;
  logic            s1_fire;

  win_t        win_q, win_n;
  logic [31:0] total_q, total_n;
  logic        ovf_q, ovf_n;
  logic [32:0] total_sum;

  logic [LenW-1:0] n_len;
  seq_t            pat, patr;
  seq_t            seq_h, seq_v, seq_d, seq_a;
  logic            col_ok, rows_ok;
  logic [HitW-1:0] hits;

  logic      out_valid_q;
  rwpc_out_t out_data_q;

  function automatic logic seq_match(input seq_t s, input seq_t p, input seq_t pr,
                                     input logic [LenW-1:0] len);
    logic fwd;
    logic rev;
    fwd = 1'b1;
    rev = 1'b1;
    for (int k = 0; k < MaxLen; k++) begin
      if (k < int'(len)) begin
        if (s[k] != p[k])  fwd = 1'b0;
        if (s[k] != pr[k]) rev = 1'b0;
      end
    end
    return fwd | rev;
  endfunction

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_chars_q <= PatternCharsRst;
      pattern_len_q   <= PatternLengthRst;
      cross_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatternChars:  pattern_chars_q <= cfg_wdata_i[31:0];
        CfgPatternLength: pattern_len_q   <= cfg_wdata_i[2:0];
        CfgCrossMode:     cross_q         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake: only a frame end meeting a held result stops the pipe
  assign stall      = s1_valid_q && s1_fe_q && out_valid_q && !out_ready_i;
  assign advance    = !stall;
  assign in_ready_o = advance;
  assign in_fire    = in_valid_i && advance;
  assign s1_fire    = s1_valid_q && advance;

  // position counters
  assign in_width0 = col_q < ColW'(MaxWidth);

  always_comb begin
    col_d  = col_q;
    rows_d = rows_q;
    if (in_fire) begin
      if (in_data_i.frame_end) begin
        col_d  = '0;
        rows_d = '0;
      end else if (in_data_i.row_end) begin
        col_d = '0;
        if (rows_q < RowW'(MaxLen - 1)) rows_d = rows_q + RowW'(1);
      end else if (in_width0) begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rows_q <= '0;
    end else begin
      col_q  <= col_d;
      rows_q <= rows_d;
    end
  end

  // line store: read at accept, write back when the item leaves stage 1
  assign wr_en = s1_fire && s1_in_width_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[s1_col_q[AddrW-1:0]] <= wr_data;
    if (in_fire && in_width0) rd_q <= line_mem[col_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_fire) begin
      fwd_q <= wr_en && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) fwd_data_q <= wr_data;
  end

  assign line_rd = fwd_q ? fwd_data_q : rd_q;

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q       <= in_data_i.char_in;
      s1_fe_q       <= in_data_i.frame_end;
      s1_col_q      <= col_q;
      s1_rows_q     <= rows_q;
      s1_in_width_q <= in_width0;
    end
  end

  // window shift and write-back word
  always_comb begin
    for (int r = 0; r < MaxLen; r++) begin
      for (int c = 1; c < MaxLen; c++) begin
        win_n[r][c] = win_q[r][c-1];
      end
    end
    win_n[0][0] = s1_ch_q;
    for (int k = 1; k < MaxLen; k++) begin
      win_n[k][0] = (s1_in_width_q && (int'(s1_rows_q) >= k)) ? line_rd[k-1] : 8'h00;
    end
    wr_data[0] = s1_ch_q;
    for (int k = 1; k < MaxLen - 1; k++) begin
      wr_data[k] = line_rd[k-1];
    end
  end

  // pattern and match
  always_comb begin
    if (int'(pattern_len_q) < 2)           n_len = LenW'(2);
    else if (int'(pattern_len_q) > MaxLen) n_len = LenW'(MaxLen);
    else                                   n_len = LenW'(pattern_len_q);

    for (int k = 0; k < MaxLen; k++) begin
      pat[k]   = 8'(pattern_chars_q >> (8 * k));
      patr[k]  = 8'h00;
      seq_h[k] = win_n[0][k];
      seq_v[k] = win_n[k][0];
      seq_d[k] = win_n[k][k];
      seq_a[k] = 8'h00;
    end
    for (int k = 0; k < MaxLen; k++) begin
      for (int j = 0; j < MaxLen; j++) begin
        if (j == int'(n_len) - 1 - k) begin
          patr[k]  = 8'(pattern_chars_q >> (8 * j));
          seq_a[k] = win_n[k][j];
        end
      end
    end

    col_ok  = s1_in_width_q && (int'(s1_col_q) >= int'(n_len) - 1);
    rows_ok = s1_in_width_q && (int'(s1_rows_q) >= int'(n_len) - 1);

    hits = '0;
    if (cross_q) begin
      if (col_ok && rows_ok && seq_match(seq_d, pat, patr, n_len)
          && seq_match(seq_a, pat, patr, n_len)) begin
        hits = HitW'(1);
      end
    end else begin
      if (col_ok)  hits = hits + HitW'(seq_match(seq_h, pat, patr, n_len));
      if (rows_ok) hits = hits + HitW'(seq_match(seq_v, pat, patr, n_len));
      if (col_ok && rows_ok) begin
        hits = hits + HitW'(seq_match(seq_d, pat, patr, n_len));
        hits = hits + HitW'(seq_match(seq_a, pat, patr, n_len));
      end
    end

    total_sum = {1'b0, total_q} + 33'(hits);
    total_n   = total_sum[32] ? '1 : total_sum[31:0];
    ovf_n     = ovf_q | !s1_in_width_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (s1_fire) begin
      win_q <= win_n;
      if (s1_fe_q) begin
        total_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        total_q <= total_n;
        ovf_q   <= ovf_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_fe_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_fe_q) begin
      out_data_q.match_total    <= total_n;
      out_data_q.width_overflow <= ovf_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/rwpc_checker.sv
`include "raster_word_pattern_counter_defines.svh"

module rwpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input rwpc_pkg::rwpc_in_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input rwpc_pkg::rwpc_out_t           out_data_o
);

  logic fe_xfer;
  logic fe_d1_q;
  logic fe_d2_q;
  logic out_stall;

  assign fe_xfer   = in_valid_i && in_ready_o && in_data_i.frame_end;
  assign out_stall = out_valid_o && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_d1_q <= 1'b0;
      fe_d2_q <= 1'b0;
    end else begin
      fe_d1_q <= fe_xfer;
      fe_d2_q <= fe_d1_q;
    end
  end

  `RWPC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o), "held result changed")
  `RWPC_ASSERT_IMP(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_o, out_stall, "input stalled early")
  `RWPC_ASSERT_IMP(a_result_from_frame_end, clk_i, rst_ni, $rose(out_valid_o), fe_d2_q, "stray result")
  `RWPC_ASSERT_IMP(a_frame_end_gives_result, clk_i, rst_ni, fe_d2_q && !$past(out_valid_o), out_valid_o, "lost result")

endmodule

bind raster_word_pattern_counter rwpc_checker u_rwpc_checker (.*);
